// ----- sv/ole_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered list engine package
// Shared constants, request and status codes, and the cell command and flag types.
// ----------------------------------------------------------------------------
package ole_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int REQ_W    = 3;
   localparam int STAT_W   = 3;
   localparam int COUNT_W  = 5;

   localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INS_FRT  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_INS_BCK  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_INS_SORT = 3'd3;
   localparam logic [REQ_W-1:0] REQ_DEL_FRT  = 3'd4;
   localparam logic [REQ_W-1:0] REQ_DEL_BCK  = 3'd5;
   localparam logic [REQ_W-1:0] REQ_DEL_KEY  = 3'd6;
   localparam logic [REQ_W-1:0] REQ_INVERT   = 3'd7;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] ST_AT_TAIL   = 3'd4;

   localparam logic [1:0] OP_HOLD = 2'd0;
   localparam logic [1:0] OP_INS  = 2'd1;
   localparam logic [1:0] OP_DEL  = 2'd2;

   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] pos;
      logic [KEY_W-1:0] key;
   } cell_cmd_type;

   typedef struct packed {
      logic gt;
      logic eq;
      logic tail;
   } cell_flag_type;

endpackage

// ----- sv/ole_cell.sv -----
// ----------------------------------------------------------------------------
// Ordered list engine cell
// Holds one entry, shifts towards or away from its neighbours on command and
// compares its entry against the probe key.
// ----------------------------------------------------------------------------
module ole_cell
   import ole_pkg::*;
(
   input  logic                    clock,
   input  logic [IDX_W-1:0]        idx,
   input  cell_cmd_type            cmd,
   input  logic [KEY_W-1:0]        left_key,
   input  logic [KEY_W-1:0]        right_key,
   input  logic [KEY_W-1:0]        probe_key,
   input  logic [CNT_W-1:0]        fill,
   output logic [KEY_W-1:0]        key_out,
   output cell_flag_type           flags
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic [CNT_W-1:0] idx_ext;
   logic             valid;

   assign idx_ext = CNT_W'(idx);
   assign valid   = idx_ext < fill;

   always_comb begin
      key_in = key_ff;
      unique case (cmd.op)
         OP_INS: begin
            if (idx > cmd.pos) begin
               key_in = left_key;
            end else if (idx == cmd.pos) begin
               key_in = cmd.key;
            end
         end
         OP_DEL: begin
            if (idx >= cmd.pos) begin
               key_in = right_key;
            end
         end
         default: begin
            key_in = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out    = key_ff;
   assign flags.gt   = valid && ($signed(key_ff) > $signed(probe_key));
   assign flags.eq   = valid && (key_ff == probe_key);
   assign flags.tail = (fill != '0) && (idx_ext == fill - CNT_W'(1));

endmodule

// ----- sv/ordered_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Ordered list engine
// Keeps an ordered list of signed keys in a row of shifting cells.
// ----------------------------------------------------------------------------
// A request is taken into the pending status register, then its result beat is
// loaded into the result register once it drains. One request can be taken every
// cycle while the result register drains; the cells compare and shift all at once.
// Reset empties the list, restores natural order and drops any pending result.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit
   import ole_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [KEY_W-1:0]      req_tdata,   // key
   input  logic [REQ_W-1:0]      req_tuser,   // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,   // entry_count, front_key, back_key, zero fill
   output logic [STAT_W-1:0]     rsp_tuser    // status
);

   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               rev_ff, rev_in;
   logic               busy_ff, busy_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic               rsp_valid_ff;
   logic [71:0]        rsp_data_ff;
   logic [STAT_W-1:0]  rsp_status_ff;

   logic               accept, load, full, empty;
   cell_cmd_type       cmd;
   cell_flag_type      flags [CAPACITY];
   logic [KEY_W-1:0]   keys  [CAPACITY];
   logic [KEY_W-1:0]   tail_key, front_key, back_key;
   logic [IDX_W-1:0]   first_gt, last_gt, first_eq, last_eq;
   logic               any_gt, any_eq;
   logic [IDX_W-1:0]   fill_idx, last_idx;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         ole_cell u_cell (
            .clock     (clock),
            .idx       (IDX_W'(g)),
            .cmd       (cmd),
            .left_key  ((g == 0) ? '0 : keys[(g == 0) ? 0 : g - 1]),
            .right_key ((g == CAPACITY - 1) ? '0 : keys[(g == CAPACITY - 1) ? g : g + 1]),
            .probe_key (req_tdata),
            .fill      (fill_ff),
            .key_out   (keys[g]),
            .flags     (flags[g])
         );
      end
   endgenerate

   always_comb begin
      first_gt = '0;
      last_gt  = '0;
      first_eq = '0;
      last_eq  = '0;
      any_gt   = 1'b0;
      any_eq   = 1'b0;
      tail_key = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (flags[i].gt) begin
            first_gt = IDX_W'(i);
         end
         if (flags[i].eq) begin
            first_eq = IDX_W'(i);
         end
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (flags[i].gt) begin
            last_gt = IDX_W'(i);
            any_gt  = 1'b1;
         end
         if (flags[i].eq) begin
            last_eq = IDX_W'(i);
            any_eq  = 1'b1;
         end
         if (flags[i].tail) begin
            tail_key = tail_key | keys[i];
         end
      end
   end

   assign load       = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy_ff || load;
   assign accept     = req_tvalid && req_tready;
   assign full       = fill_ff == CNT_W'(CAPACITY);
   assign empty      = fill_ff == '0;
   assign fill_idx   = IDX_W'(fill_ff);
   assign last_idx   = IDX_W'(fill_ff - CNT_W'(1));

   always_comb begin
      cmd.op    = OP_HOLD;
      cmd.pos   = '0;
      cmd.key   = req_tdata;
      fill_in   = fill_ff;
      rev_in    = rev_ff;
      status_in = ST_OK;
      if (accept) begin
         unique case (req_tuser) inside
            REQ_CLEAR: begin
               fill_in = '0;
               rev_in  = 1'b0;
            end
            REQ_INS_FRT, REQ_INS_BCK, REQ_INS_SORT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.op  = OP_INS;
                  fill_in = fill_ff + CNT_W'(1);
                  if (req_tuser == REQ_INS_FRT) begin
                     cmd.pos = rev_ff ? fill_idx : '0;
                  end else if (req_tuser == REQ_INS_BCK) begin
                     cmd.pos = rev_ff ? '0 : fill_idx;
                  end else begin
                     if (!any_gt && !empty) begin
                        status_in = ST_AT_TAIL;
                     end
                     if (rev_ff) begin
                        cmd.pos = any_gt ? IDX_W'(CNT_W'(last_gt) + CNT_W'(1)) : '0;
                     end else begin
                        cmd.pos = any_gt ? first_gt : fill_idx;
                     end
                  end
               end
            end
            REQ_DEL_FRT, REQ_DEL_BCK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  cmd.op  = OP_DEL;
                  fill_in = fill_ff - CNT_W'(1);
                  cmd.pos = ((req_tuser == REQ_DEL_FRT) == rev_ff) ? last_idx : '0;
               end
            end
            REQ_DEL_KEY: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else if (!any_eq) begin
                  status_in = ST_NOT_FOUND;
               end else begin
                  cmd.op  = OP_DEL;
                  fill_in = fill_ff - CNT_W'(1);
                  cmd.pos = rev_ff ? last_eq : first_eq;
               end
            end
            default: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rev_in = !rev_ff;
               end
            end
         endcase
      end
   end

   assign busy_in   = accept ? 1'b1 : (load ? 1'b0 : busy_ff);
   assign front_key = empty ? '0 : (rev_ff ? tail_key : keys[0]);
   assign back_key  = empty ? '0 : (rev_ff ? keys[0] : tail_key);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rev_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         rev_ff  <= rev_in;
         busy_ff <= busy_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
      if (load) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= {3'b000, back_key, front_key, COUNT_W'(fill_ff)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted request not pending");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == REQ_CLEAR |=> fill_ff == '0 && !rev_ff)
      else $error("clear left entries or reversed order");

   a_full_refused : assert property (@(posedge clock) disable iff (reset)
      accept && full && (req_tuser == REQ_INS_FRT || req_tuser == REQ_INS_BCK
                         || req_tuser == REQ_INS_SORT) |=> fill_ff == $past(fill_ff))
      else $error("insert into full list changed the count");

endmodule
